/* hdl/websocket_frame_unmasker_macros.svh */
// assertion helpers for the parser rtl file
`ifndef WEBSOCKET_FRAME_UNMASKER_MACROS_SVH
`define WEBSOCKET_FRAME_UNMASKER_MACROS_SVH

// same-cycle implication, quiet while in reset
`define WSFU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfu assertion failed");

// next-cycle implication, quiet while in reset
`define WSFU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfu assertion failed");

`endif

/* hdl/wsfu_pkg.sv */
`timescale 1ns / 1ps

package wsfu_pkg;

    localparam logic [7:0] FIRST_BYTE_TEXT = 8'h81;
    localparam logic [6:0] LEN_CODE_EXT16  = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64  = 7'd127;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_LEN   = 3'd1,
        PH_EXT   = 3'd2,
        PH_KEY   = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_BAD_FIRST = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_LEN64     = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        status_t    status;
    } result_t;

endpackage

/* hdl/wsfu_parser.sv */
`timescale 1ns / 1ps

`include "websocket_frame_unmasker_macros.svh"

module wsfu_parser
    import wsfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic        discard_reg, discard_next;

    logic [6:0]  len_code;
    logic [7:0]  key_byte;
    logic [7:0]  unmasked;
    logic [15:0] remain_dec;

    assign len_code   = in_byte[6:0];
    assign key_byte   = key_reg[{key_pos_reg, 3'b000} +: 8];
    assign unmasked   = in_byte ^ key_byte;
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        remain_next    = remain_reg;
        key_next       = key_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        key_pos_next   = key_pos_reg;
        discard_next   = discard_reg;
        res            = '{valid: 1'b0, data: 8'd0, last: 1'b0, status: ST_DATA};

        if (fire)
        begin
            if (discard_reg)
            begin
                if (in_end)
                begin
                    discard_next = 1'b0;
                    phase_next   = PH_FIRST;
                    hdr_cnt_next = 2'd0;
                    key_pos_next = 2'd0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (in_byte != FIRST_BYTE_TEXT)
                        begin
                            res          = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                             status: ST_BAD_FIRST};
                            discard_next = !in_end;
                        end
                        else if (in_end)
                        begin
                            res = '{valid: 1'b1, data: 8'd0, last: 1'b1, status: ST_TRUNC};
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        if (len_code == LEN_CODE_EXT64)
                        begin
                            res          = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                             status: ST_LEN64};
                            phase_next   = PH_FIRST;
                            discard_next = !in_end;
                        end
                        else if (in_end)
                        begin
                            res        = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                           status: ST_TRUNC};
                            phase_next = PH_FIRST;
                        end
                        else if (len_code == LEN_CODE_EXT16)
                        begin
                            hdr_cnt_next   = 2'd0;
                            frame_len_next = 16'd0;
                            phase_next     = PH_EXT;
                        end
                        else
                        begin
                            hdr_cnt_next   = 2'd0;
                            frame_len_next = {9'd0, len_code};
                            phase_next     = PH_KEY;
                        end
                    end
                    PH_EXT:
                    begin
                        if (in_end)
                        begin
                            res          = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                             status: ST_TRUNC};
                            phase_next   = PH_FIRST;
                            hdr_cnt_next = 2'd0;
                        end
                        else
                        begin
                            frame_len_next = {frame_len_reg[7:0], in_byte};
                            if (hdr_cnt_reg == 2'd1)
                            begin
                                hdr_cnt_next = 2'd0;
                                phase_next   = PH_KEY;
                            end
                            else
                            begin
                                hdr_cnt_next = 2'd1;
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        key_next[{hdr_cnt_reg, 3'b000} +: 8] = in_byte;
                        if (hdr_cnt_reg == 2'd3)
                        begin
                            hdr_cnt_next = 2'd0;
                            if (frame_len_reg == 16'd0)
                            begin
                                res          = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                                 status: ST_EMPTY};
                                phase_next   = PH_FIRST;
                                discard_next = !in_end;
                            end
                            else if (in_end)
                            begin
                                res        = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                               status: ST_TRUNC};
                                phase_next = PH_FIRST;
                            end
                            else
                            begin
                                remain_next  = frame_len_reg;
                                key_pos_next = 2'd0;
                                phase_next   = PH_DATA;
                            end
                        end
                        else if (in_end)
                        begin
                            res          = '{valid: 1'b1, data: 8'd0, last: 1'b1,
                                             status: ST_TRUNC};
                            phase_next   = PH_FIRST;
                            hdr_cnt_next = 2'd0;
                        end
                        else
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        end
                    end
                    PH_DATA:
                    begin
                        remain_next  = remain_dec;
                        key_pos_next = key_pos_reg + 2'd1;
                        if (remain_dec == 16'd0)
                        begin
                            res          = '{valid: 1'b1, data: unmasked, last: 1'b1,
                                             status: ST_DATA};
                            phase_next   = PH_FIRST;
                            key_pos_next = 2'd0;
                            discard_next = !in_end;
                        end
                        else if (in_end)
                        begin
                            res          = '{valid: 1'b1, data: unmasked, last: 1'b1,
                                             status: ST_TRUNC};
                            phase_next   = PH_FIRST;
                            key_pos_next = 2'd0;
                        end
                        else
                        begin
                            res = '{valid: 1'b1, data: unmasked, last: 1'b0,
                                    status: ST_DATA};
                        end
                    end
                    default:
                    begin
                        phase_next   = PH_FIRST;
                        hdr_cnt_next = 2'd0;
                        key_pos_next = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            frame_len_reg <= 16'd0;
            remain_reg    <= 16'd0;
            key_reg       <= 32'd0;
            hdr_cnt_reg   <= 2'd0;
            key_pos_reg   <= 2'd0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            remain_reg    <= remain_next;
            key_reg       <= key_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            key_pos_reg   <= key_pos_next;
            discard_reg   <= discard_next;
        end
    end

    // dropping the tail of a buffer never produces output
    `WSFU_ASSERT_IMP(a_discard_silent, clk, rst_n, discard_reg && fire, !res.valid)
    // discard mode only ever waits for the next frame start
    `WSFU_ASSERT_IMP(a_discard_phase, clk, rst_n, discard_reg, phase_reg == PH_FIRST)
    // payload phase always has at least one byte left
    `WSFU_ASSERT_IMP(a_data_remain, clk, rst_n, phase_reg == PH_DATA, remain_reg != 16'd0)
    // any error or empty status closes the frame
    `WSFU_ASSERT_IMP(a_status_last, clk, rst_n, res.valid && res.status != ST_DATA, res.last)
    // after an error status the parser is back at the frame start
    `WSFU_ASSERT_NXT(a_status_restart, clk, rst_n,
        fire && res.valid && res.status != ST_DATA, phase_reg == PH_FIRST)

endmodule

/* hdl/websocket_frame_unmasker.sv */
`timescale 1ns / 1ps

// receive-side deframer for client-to-server websocket frames, one byte per beat
// slave channel: raw frame bytes on s_tdata, s_tlast marks the last byte of a buffer
// master channel: unmasked payload bytes on m_tdata, m_tlast on the last byte of a
//   frame and on every status request, m_tuser carries the frame status
//   (0 data, 1 bad first byte, 2 empty payload, 3 64-bit length, 4 truncated)
// header, length and key bytes produce no output unless they end the frame with a status;
//   bytes after a finished frame are dropped up to s_tlast
// a byte accepted into the input register is parsed combinationally from there and its
//   result is registered in the output register when that register is free or draining
// throughput: one byte per cycle while m_tready does not stall a pending result, set by the
//   single register-to-register parse step between the input register and the output register
// when m_tready is low with a result pending, the input register takes at most one
//   more byte, then s_tready falls until the output is taken
// reset (rst_n low, asynchronous) empties both registers and returns the parser to
//   the first header byte with a zero key and lengths
module websocket_frame_unmasker
    import wsfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // buffer_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic       m_tlast,   // payload_last
    output logic [2:0] m_tuser    // [2:0] frame_status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    status_t    out_status_reg;
    logic       fire;
    result_t    res;

    // parse a held byte whenever the output register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    wsfu_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .res     (res)
    );

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = res.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            out_byte_reg   <= res.data;
            out_last_reg   <= res.last;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule
